// ===== rtl/lcd_mode_timing_sequencer_defines.svh =====
// assertion helpers, sampled on i_clk and disabled while i_rst_n is low
`ifndef LCD_MODE_TIMING_SEQUENCER_DEFINES_SVH
`define LCD_MODE_TIMING_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define LMTS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LMTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lmts_pkg.sv =====
package lmts_pkg;

    localparam int ELAPSED_W = 6;
    localparam int ACC_W     = 10;
    localparam int LINE_W    = 8;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_XFER   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        REG_DISPLAY_ENABLE    = 2'd0,
        REG_LINE_COMPARE      = 2'd1,
        REG_VBLANK_IRQ_ENABLE = 2'd2
    } t_reg_idx;

    localparam logic [ACC_W-1:0] CYC_OAM    = 10'd80;
    localparam logic [ACC_W-1:0] CYC_XFER   = 10'd172;
    localparam logic [ACC_W-1:0] CYC_HBLANK = 10'd204;
    localparam logic [ACC_W-1:0] CYC_LINE   = 10'd456;
    localparam logic [ACC_W-1:0] ACC_MAX    = 10'd1023;

    localparam logic [LINE_W-1:0] FIRST_VBLANK_LINE = 8'd144;
    localparam logic [LINE_W-1:0] LAST_LINE         = 8'd153;

endpackage

// ===== rtl/lmts_if.sv =====
interface lmts_in_if;
    import lmts_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ELAPSED_W-1:0] elapsed_cycles;

    modport source (output valid, output elapsed_cycles, input ready);
    modport sink   (input valid, input elapsed_cycles, output ready);
endinterface

interface lmts_out_if;
    import lmts_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic [LINE_W-1:0] line;
    logic              coincidence;
    logic              vblank_irq;
    logic              render_pulse;
    logic              frame_done;

    modport source (
        output valid, output mode, output line, output coincidence,
        output vblank_irq, output render_pulse, output frame_done, input ready
    );
    modport sink (
        input valid, input mode, input line, input coincidence,
        input vblank_irq, input render_pulse, input frame_done, output ready
    );
endinterface

// ===== rtl/lcd_mode_timing_sequencer.sv =====
// output: each result is registered and shown in the cycle after its input transaction
// throughput: one item per clock while the output is not stalled, set by the combinational mode
// step between the timing state registers and the output register; an output stall blocks input
// unless the output register is empty or can be emptied in the same cycle
// reset (synchronous, active low): mode pixel transfer, line and accumulator zero,
// configuration registers zero, output register empty
`include "lcd_mode_timing_sequencer_defines.svh"

module lcd_mode_timing_sequencer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    lmts_in_if.sink                     i_item,
    lmts_out_if.source                  o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lmts_pkg::ADDR_W-1:0] paddr,
    input  logic [lmts_pkg::DATA_W-1:0] pwdata,
    output logic [lmts_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import lmts_pkg::*;

    logic              r_display_enable;
    logic [LINE_W-1:0] r_line_compare;
    logic              r_vblank_irq_enable;

    logic [ACC_W-1:0]  r_acc;
    t_mode             r_mode;
    logic [LINE_W-1:0] r_line;

    logic [ACC_W-1:0]  n_acc;
    t_mode             n_mode;
    logic [LINE_W-1:0] n_line;
    logic              n_irq;
    logic              n_render;
    logic              n_frame;

    logic              r_out_valid;
    t_mode             r_out_mode;
    logic [LINE_W-1:0] r_out_line;
    logic              r_out_coincidence;
    logic              r_out_irq;
    logic              r_out_render;
    logic              r_out_frame;

    logic              in_acc;
    logic              cfg_wr;
    t_reg_idx          cfg_idx;
    logic [ACC_W:0]    sum;
    logic [ACC_W-1:0]  acc_sat;
    logic [LINE_W-1:0] line_inc;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);

    always_comb begin
        case (cfg_idx)
            REG_DISPLAY_ENABLE:    prdata = {{(DATA_W-1){1'b0}}, r_display_enable};
            REG_LINE_COMPARE:      prdata = {{(DATA_W-LINE_W){1'b0}}, r_line_compare};
            REG_VBLANK_IRQ_ENABLE: prdata = {{(DATA_W-1){1'b0}}, r_vblank_irq_enable};
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_enable    <= 1'b0;
            r_line_compare      <= '0;
            r_vblank_irq_enable <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_DISPLAY_ENABLE:    r_display_enable    <= pwdata[0];
                REG_LINE_COMPARE:      r_line_compare      <= pwdata[LINE_W-1:0];
                REG_VBLANK_IRQ_ENABLE: r_vblank_irq_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    // handshake: output register can be refilled in the cycle it drains
    assign i_item.ready = !r_out_valid || o_result.ready;
    assign in_acc       = i_item.valid && i_item.ready;

    // mode step
    assign sum      = {1'b0, r_acc} + {{(ACC_W+1-ELAPSED_W){1'b0}}, i_item.elapsed_cycles};
    assign acc_sat  = sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
    assign line_inc = r_line + 8'd1;

    always_comb begin
        n_acc    = r_acc;
        n_mode   = r_mode;
        n_line   = r_line;
        n_irq    = 1'b0;
        n_render = 1'b0;
        n_frame  = 1'b0;
        if (r_display_enable) begin
            n_acc = acc_sat;
            case (r_mode)
                MODE_HBLANK: begin
                    if (acc_sat >= CYC_HBLANK) begin
                        n_acc  = acc_sat - CYC_HBLANK;
                        n_line = line_inc;
                        if (line_inc == FIRST_VBLANK_LINE) begin
                            n_mode = MODE_VBLANK;
                            n_irq  = r_vblank_irq_enable;
                        end else begin
                            n_mode = MODE_OAM;
                        end
                    end
                end
                MODE_VBLANK: begin
                    if (acc_sat >= CYC_LINE) begin
                        n_acc  = acc_sat - CYC_LINE;
                        n_line = line_inc;
                        // wrap after the last vblank line
                        if (line_inc > LAST_LINE) begin
                            n_line  = '0;
                            n_mode  = MODE_OAM;
                            n_frame = 1'b1;
                        end
                    end
                end
                MODE_OAM: begin
                    if (acc_sat >= CYC_OAM) begin
                        n_acc  = acc_sat - CYC_OAM;
                        n_mode = MODE_XFER;
                    end
                end
                default: begin
                    if (acc_sat >= CYC_XFER) begin
                        n_acc    = acc_sat - CYC_XFER;
                        n_mode   = MODE_HBLANK;
                        n_render = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_mode <= MODE_XFER;
            r_line <= '0;
        end else if (in_acc) begin
            r_acc  <= n_acc;
            r_mode <= n_mode;
            r_line <= n_line;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_mode        <= n_mode;
            r_out_line        <= n_line;
            r_out_coincidence <= (n_line == r_line_compare);
            r_out_irq         <= n_irq;
            r_out_render      <= n_render;
            r_out_frame       <= n_frame;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.mode         = r_out_mode;
    assign o_result.line         = r_out_line;
    assign o_result.coincidence  = r_out_coincidence;
    assign o_result.vblank_irq   = r_out_irq;
    assign o_result.render_pulse = r_out_render;
    assign o_result.frame_done   = r_out_frame;

    `LMTS_ASSERT_SAME(a_pulses_exclusive, r_out_valid,
        $onehot0({r_out_irq, r_out_render, r_out_frame}), "more than one pulse in a result")
    `LMTS_ASSERT_SAME(a_line_in_range, 1'b1, r_line <= LAST_LINE,
        "line counter beyond last line")
    `LMTS_ASSERT_NEXT(a_frozen_when_off, in_acc && !r_display_enable,
        $stable(r_acc) && $stable(r_mode) && $stable(r_line),
        "timing state moved while display disabled")
    `LMTS_ASSERT_SAME(a_render_enters_hblank, r_out_valid && r_out_render,
        r_out_mode == MODE_HBLANK, "render pulse without entering hblank")
    `LMTS_ASSERT_SAME(a_frame_wraps_line, r_out_valid && r_out_frame,
        r_out_line == '0 && r_out_mode == MODE_OAM, "frame done without line wrap")

endmodule

// ===== verif/lcd_mode_timing_sequencer_checker.sv =====
`timescale 1ns / 1ps

module lcd_mode_timing_sequencer_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    lmts_in_if                          i_item,
    lmts_out_if                         i_result,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic                        i_pready,
    input  logic [lmts_pkg::ADDR_W-1:0] i_paddr,
    input  logic [lmts_pkg::DATA_W-1:0] i_pwdata,
    output int                          o_errors,
    output int                          o_pending,
    output int                          o_frames,
    output int                          o_irqs,
    output int                          o_renders
);
    import lmts_pkg::*;

    typedef struct packed {
        t_mode             mode;
        logic [LINE_W-1:0] line;
        logic              coincidence;
        logic              vblank_irq;
        logic              render_pulse;
        logic              frame_done;
    } t_lcd_status;

    // register copies, written when a write transaction completes
    logic              lcd_on;
    logic [LINE_W-1:0] cmp_line;
    logic              irq_on;

    // timing state of the prediction
    logic [ACC_W-1:0]  acc_q;
    t_mode             mode_q;
    logic [LINE_W-1:0] line_q;

    t_lcd_status       expected_status_q[$];
    int                errors  = 0;
    int                frames  = 0;
    int                irqs    = 0;
    int                renders = 0;
    int                pending_q = 0;

    assign o_errors  = errors;
    assign o_pending = pending_q;
    assign o_frames  = frames;
    assign o_irqs    = irqs;
    assign o_renders = renders;

    function automatic t_lcd_status step_timing(input logic [ELAPSED_W-1:0] elapsed);
        t_lcd_status st;
        int          sum;
        st = '0;
        if (lcd_on) begin
            sum = int'(acc_q) + int'(elapsed);
            if (sum > int'(ACC_MAX)) begin
                sum = int'(ACC_MAX);
            end
            case (mode_q)
                MODE_HBLANK: begin
                    if (sum >= int'(CYC_HBLANK)) begin
                        sum -= int'(CYC_HBLANK);
                        line_q = line_q + 8'd1;
                        if (line_q == FIRST_VBLANK_LINE) begin
                            mode_q = MODE_VBLANK;
                            st.vblank_irq = irq_on;
                        end else begin
                            mode_q = MODE_OAM;
                        end
                    end
                end
                MODE_VBLANK: begin
                    if (sum >= int'(CYC_LINE)) begin
                        sum -= int'(CYC_LINE);
                        line_q = line_q + 8'd1;
                        // past the last vblank line the frame wraps
                        if (line_q > LAST_LINE) begin
                            line_q = '0;
                            mode_q = MODE_OAM;
                            st.frame_done = 1'b1;
                        end
                    end
                end
                MODE_OAM: begin
                    if (sum >= int'(CYC_OAM)) begin
                        sum -= int'(CYC_OAM);
                        mode_q = MODE_XFER;
                    end
                end
                default: begin
                    if (sum >= int'(CYC_XFER)) begin
                        sum -= int'(CYC_XFER);
                        mode_q = MODE_HBLANK;
                        st.render_pulse = 1'b1;
                    end
                end
            endcase
            acc_q = ACC_W'(sum);
        end
        st.mode        = mode_q;
        st.line        = line_q;
        st.coincidence = (line_q == cmp_line);
        return st;
    endfunction

    task automatic report_failure(input string msg);
        $display("%0t: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) begin
            report_failure($sformatf("%s mismatch: got %0d, expected %0d", name, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        t_lcd_status want;
        if (!i_rst_n) begin
            lcd_on   = 1'b0;
            cmp_line = '0;
            irq_on   = 1'b0;
            acc_q    = '0;
            mode_q   = MODE_XFER;
            line_q   = '0;
            expected_status_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[ADDR_W-1:2])
                    REG_DISPLAY_ENABLE:    lcd_on   = i_pwdata[0];
                    REG_LINE_COMPARE:      cmp_line = i_pwdata[LINE_W-1:0];
                    REG_VBLANK_IRQ_ENABLE: irq_on   = i_pwdata[0];
                    default: ;
                endcase
            end
            // results are registered and leave no earlier than the cycle after their input, so check before pushing
            if (i_result.valid && i_result.ready) begin
                if (expected_status_q.size() == 0) begin
                    report_failure($sformatf("result with no transaction waiting: mode %0d line %0d",
                                             i_result.mode, i_result.line));
                end else begin
                    want = expected_status_q.pop_front();
                    check_field("mode", 8'(i_result.mode), 8'(want.mode));
                    check_field("line", i_result.line, want.line);
                    check_field("coincidence", 8'(i_result.coincidence), 8'(want.coincidence));
                    check_field("vblank_irq", 8'(i_result.vblank_irq), 8'(want.vblank_irq));
                    check_field("render_pulse", 8'(i_result.render_pulse),
                                8'(want.render_pulse));
                    check_field("frame_done", 8'(i_result.frame_done), 8'(want.frame_done));
                end
            end
            if (i_item.valid && i_item.ready) begin
                want = step_timing(i_item.elapsed_cycles);
                frames  += int'(want.frame_done);
                irqs    += int'(want.vblank_irq);
                renders += int'(want.render_pulse);
                expected_status_q.push_back(want);
            end
        end
        pending_q <= expected_status_q.size();
    end

endmodule

// ===== verif/lcd_mode_timing_sequencer_tb.sv =====
`timescale 1ns / 1ps

module lcd_mode_timing_sequencer_tb;
    import lmts_pkg::*;

    localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = 4'd12;
    localparam int N_PHASES = 5;
    localparam int PHASE_ITEMS  [N_PHASES] = '{400, 100, 500, 600, 350};
    localparam bit PHASE_LCD_ON [N_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
    localparam bit PHASE_IRQ_ON [N_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    localparam int DRAIN_LIMIT = 1000;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    lmts_in_if  item_if ();
    lmts_out_if result_if ();

    bit idle_on    = 1'b0;
    int stall_left = 0;
    int items_sent = 0;
    int errors;
    int pending;
    int frames;
    int irqs;
    int renders;

    lcd_mode_timing_sequencer dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (result_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    lcd_mode_timing_sequencer_checker timing_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (item_if),
        .i_result  (result_if),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_pready  (pready),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_errors  (errors),
        .o_pending (pending),
        .o_frames  (frames),
        .o_irqs    (irqs),
        .o_renders (renders)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("lcd_mode_timing_sequencer_tb failed");
        $finish;
    end

    // output back-pressure in bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            result_if.ready <= (stall_left == 1);
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(1, 6);
            result_if.ready <= 1'b0;
        end else begin
            result_if.ready <= 1'b1;
        end
    end

    task automatic send_item(input logic [ELAPSED_W-1:0] cycles);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 6);
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid          <= 1'b1;
        item_if.elapsed_cycles <= cycles;
        do @(posedge i_clk); while (!item_if.ready);
        items_sent++;
    endtask

    // stop sending and let every outstanding result come out
    task automatic wait_drained();
        item_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // upper data bits carry noise, the block must ignore them
    task automatic set_config(input bit lcd_on, input logic [LINE_W-1:0] cmp, input bit irq_on);
        apb_write({REG_DISPLAY_ENABLE, 2'b00}, ($urandom() & 32'hFFFF_FFFE) | DATA_W'(lcd_on));
        apb_write({REG_LINE_COMPARE, 2'b00}, ($urandom() & 32'hFFFF_FF00) | DATA_W'(cmp));
        apb_write({REG_VBLANK_IRQ_ENABLE, 2'b00},
                  ($urandom() & 32'hFFFF_FFFE) | DATA_W'(irq_on));
    endtask

    // biased toward long steps so the run gets through vblank and a frame wrap
    function automatic logic [ELAPSED_W-1:0] pick_elapsed();
        case ($urandom_range(0, 3))
            0, 1:    return ELAPSED_W'($urandom_range(56, 63));
            2:       return ELAPSED_W'($urandom_range(32, 63));
            default: return ELAPSED_W'($urandom_range(0, 63));
        endcase
    endfunction

    initial begin
        logic [ELAPSED_W-1:0] directed [18];
        logic [LINE_W-1:0]    cmp;
        int                   drain_cycles;

        directed = '{6'd0, 6'd1, 6'd2, 6'd4, 6'd8, 6'd16, 6'd32, 6'd63, 6'd63, 6'd63,
                     6'd42, 6'd21, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63};

        i_rst_n                <= 1'b0;
        item_if.valid          <= 1'b0;
        item_if.elapsed_cycles <= '0;
        psel                   <= 1'b0;
        penable                <= 1'b0;
        pwrite                 <= 1'b0;
        paddr                  <= '0;
        pwdata                 <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // display still off after reset: input ignored, state frozen
        send_item(6'd63);
        send_item(6'd0);
        send_item(6'd42);
        send_item(6'd21);
        wait_drained();

        set_config(1'b1, 8'd1, 1'b1);
        apb_write(UNMAPPED_ADDR, $urandom());
        foreach (directed[k]) begin
            send_item(directed[k]);
        end

        for (int phase = 0; phase < N_PHASES; phase++) begin
            wait_drained();
            case (phase)
                0:       cmp = LINE_W'($urandom_range(1, 40));
                1:       cmp = 8'd255;
                2:       cmp = LINE_W'($urandom_range(45, 90));
                3:       cmp = LAST_LINE;
                default: cmp = '0;
            endcase
            set_config(PHASE_LCD_ON[phase], cmp, PHASE_IRQ_ON[phase]);
            idle_on = (phase != N_PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS[phase]; n++) begin
                // hold off once mid-phase until everything in flight is out
                if (phase == 2 && n == 250) begin
                    wait_drained();
                end
                send_item(pick_elapsed());
            end
        end

        item_if.valid <= 1'b0;
        drain_cycles = 0;
        do begin
            @(posedge i_clk);
            drain_cycles++;
        end while (pending != 0 && drain_cycles < DRAIN_LIMIT);
        repeat (4) @(posedge i_clk);

        $display("checked %0d transactions over %0d register settings", items_sent,
                 N_PHASES + 2);
        $display("seen %0d render pulses, %0d vblank irqs, %0d frame wraps", renders, irqs,
                 frames);
        if (errors == 0 && pending == 0) begin
            $display("lcd_mode_timing_sequencer_tb passed");
        end else begin
            $display("lcd_mode_timing_sequencer_tb failed");
        end
        $finish;
    end

endmodule
